[design/olist_pkg.sv]
// olist_pkg: request and status codes, control state and cell control types
// for the ordered list engine; no dependencies
`timescale 1ns / 1ps

package olist_pkg;

    typedef enum logic [3:0] {
        REQ_APPEND       = 4'd0,
        REQ_INSERT       = 4'd1,
        REQ_SET          = 4'd2,
        REQ_READ         = 4'd3,
        REQ_READ_LAST    = 4'd4,
        REQ_CONTAINS     = 4'd5,
        REQ_REMOVE_VALUE = 4'd6,
        REQ_REMOVE_AT    = 4'd7,
        REQ_REMOVE_LAST  = 4'd8,
        REQ_CLEAR        = 4'd9
    } t_req;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_CAPTURE = 4'b0010,
        S_SCAN    = 4'b0100,
        S_APPLY   = 4'b1000
    } t_state;

    typedef struct packed {
        logic capture;
        logic scan;
        logic apply;
        logic ok;
        t_req op;
    } t_cell_ctl;

    localparam int IN_W  = 48;
    localparam int OUT_W = 48;

endpackage

[design/olist_cell.sv]
// olist_cell: one list entry with its match flag, match-above chain and read chain
// depends on olist_pkg
`timescale 1ns / 1ps

module olist_cell #(
    parameter int IDX        = 0,
    parameter int CNT_W      = 7,
    parameter int WORD_WIDTH = 32
) (
    input  logic                    i_clk,
    input  olist_pkg::t_cell_ctl    i_ctl,
    input  logic [WORD_WIDTH-1:0]   i_word,
    input  logic [CNT_W-1:0]        i_tgt,
    input  logic [CNT_W-1:0]        i_count,
    input  logic [WORD_WIDTH-1:0]   i_entry_up,
    input  logic [WORD_WIDTH-1:0]   i_entry_dn,
    input  logic                    i_hit_up,
    input  logic                    i_above_up,
    input  logic [WORD_WIDTH-1:0]   i_rd_up,
    output logic [WORD_WIDTH-1:0]   o_entry,
    output logic                    o_hit,
    output logic                    o_above,
    output logic [WORD_WIDTH-1:0]   o_rd
);
    import olist_pkg::*;

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [WORD_WIDTH-1:0] r_entry, n_entry;
    logic                  r_hit, n_hit;
    logic                  r_above, n_above;
    logic [WORD_WIDTH-1:0] r_rd, n_rd;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.apply && i_ctl.ok) begin
            case (i_ctl.op)
                REQ_APPEND, REQ_SET: begin
                    if (IDX_C == i_tgt) n_entry = i_word;
                end
                REQ_INSERT: begin
                    if (IDX_C == i_tgt) n_entry = i_word;
                    else if (IDX_C > i_tgt) n_entry = i_entry_dn;
                end
                REQ_REMOVE_VALUE: begin
                    if (!r_above) n_entry = i_entry_up;
                end
                REQ_REMOVE_AT: begin
                    if (IDX_C >= i_tgt) n_entry = i_entry_up;
                end
                default: n_entry = r_entry;
            endcase
        end
    end

    always_comb begin
        n_hit   = r_hit;
        n_above = r_above;
        n_rd    = r_rd;
        if (i_ctl.capture) begin
            n_hit   = (r_entry == i_word) && (IDX_C < i_count);
            n_above = 1'b0;
        end else if (i_ctl.scan) begin
            n_above = i_above_up | i_hit_up;
            n_rd    = (IDX_C == i_tgt) ? r_entry : i_rd_up;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_hit   <= n_hit;
        r_above <= n_above;
        r_rd    <= n_rd;
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;
    assign o_above = r_above;
    assign o_rd    = r_rd;

endmodule

[design/ordered_list_engine_core.sv]
// ordered_list_engine_core: bounded ordered word list built as a row of entry cells
// depends on olist_pkg and olist_cell
`timescale 1ns / 1ps
//
//  channel   dir  fields (tdata, lowest bit up)
//  s_axis    in   req_type[3:0] value[35:4] position[42:36], zero fill to 48
//  m_axis    out  read_data[31:0] found[32] status[34:33] entry_count[41:35]
//                 is_empty[42], zero fill to 48
//
//  every request passes from accept to result valid through capture of per-cell
//  matches, the scan in which the match and read chains ripple down the cell
//  row, and the update of cells and count
//  one request in flight; the next word is taken the cycle after the update,
//  even while the last result waits
//  the update stalls while an untaken result sits in the output register
//  reset clears the fill count and control; entries need no clearing

module ordered_list_engine_core #(
    parameter int CAPACITY   = 64,
    parameter int WORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [olist_pkg::IN_W-1:0]    s_axis_tdata,  // req_type, value, position
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [olist_pkg::OUT_W-1:0]   m_axis_tdata   // read_data, found, status,
                                                         // entry_count, is_empty
);
    import olist_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
    localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] LAST_C = CNT_W'(CAPACITY - 1);

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_scan;
    t_req                 r_op;
    logic                 r_ok;
    t_status              r_st;
    logic [CNT_W-1:0]     r_tgt;
    logic [WORD_WIDTH-1:0] r_word;
    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;

    t_req                 w_req;
    logic [31:0]          w_value;
    logic [6:0]           w_pos;
    logic [CMP_W-1:0]     w_pos_c, w_cnt_c;
    logic [95:0]          w_value_ext;
    logic [WORD_WIDTH-1:0] w_word;
    logic                 w_accept, w_full, w_out_free, w_hit_any;
    logic                 n_ok;
    t_status              n_st;
    logic [CNT_W-1:0]     n_tgt;
    t_cell_ctl            w_ctl;

    logic [WORD_WIDTH-1:0] w_entry [CAPACITY];
    logic                  w_hit   [CAPACITY];
    logic                  w_above [CAPACITY];
    logic [WORD_WIDTH-1:0] w_rd    [CAPACITY];

    logic [WORD_WIDTH+31:0] w_rd_ext;
    logic [CNT_W+6:0]       w_count_ext;
    logic [31:0]            w_rdata;
    logic                   w_found;

    assign w_req       = t_req'(s_axis_tdata[3:0]);
    assign w_value     = s_axis_tdata[35:4];
    assign w_pos       = s_axis_tdata[42:36];
    assign w_pos_c     = CMP_W'(w_pos);
    assign w_cnt_c     = CMP_W'(r_count);
    assign w_value_ext = {64'd0, w_value};
    assign w_word      = w_value_ext[WORD_WIDTH-1:0];
    assign w_full      = (r_count >= CAP_C);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    always_comb begin
        n_ok  = 1'b1;
        n_st  = ST_OK;
        n_tgt = CNT_W'(w_pos);
        unique case (w_req)
            REQ_APPEND: begin
                n_tgt = r_count;
                if (w_full) begin
                    n_ok = 1'b0;
                    n_st = ST_FULL;
                end
            end
            REQ_INSERT: begin
                if (w_pos_c > w_cnt_c) begin
                    n_ok = 1'b0;
                    n_st = ST_BAD;
                end else if (w_full) begin
                    n_ok = 1'b0;
                    n_st = ST_FULL;
                end
            end
            REQ_SET, REQ_READ, REQ_REMOVE_AT: begin
                if (w_pos_c >= w_cnt_c) begin
                    n_ok = 1'b0;
                    n_st = ST_BAD;
                end
            end
            REQ_READ_LAST, REQ_REMOVE_LAST: begin
                n_tgt = r_count - CNT_W'(1);
                if (r_count == '0) begin
                    n_ok = 1'b0;
                    n_st = ST_BAD;
                end
            end
            default: n_ok = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (w_accept) n_state = S_CAPTURE;
            S_CAPTURE: n_state = S_SCAN;
            S_SCAN:    if (r_scan == LAST_C) n_state = S_APPLY;
            S_APPLY:   if (w_out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    assign w_hit_any = w_hit[0] | w_above[0];

    always_comb begin
        w_ctl.capture = (r_state == S_CAPTURE);
        w_ctl.scan    = (r_state == S_SCAN);
        w_ctl.apply   = (r_state == S_APPLY) && w_out_free;
        w_ctl.ok      = (r_op == REQ_REMOVE_VALUE) ? w_hit_any : r_ok;
        w_ctl.op      = r_op;
    end

    always_comb begin
        n_count = r_count;
        case (r_op)
            REQ_APPEND, REQ_INSERT: begin
                if (r_ok) n_count = r_count + CNT_W'(1);
            end
            REQ_REMOVE_AT, REQ_REMOVE_LAST: begin
                if (r_ok) n_count = r_count - CNT_W'(1);
            end
            REQ_REMOVE_VALUE: begin
                if (w_hit_any) n_count = r_count - CNT_W'(1);
            end
            REQ_CLEAR: n_count = '0;
            default:   n_count = r_count;
        endcase
    end

    assign w_rd_ext    = {32'd0, w_rd[0]};
    assign w_rdata     = ((r_op == REQ_READ || r_op == REQ_READ_LAST) && r_ok)
                         ? w_rd_ext[31:0] : 32'd0;
    assign w_found     = (r_op == REQ_CONTAINS || r_op == REQ_REMOVE_VALUE) && w_hit_any;
    assign w_count_ext = {7'd0, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.capture) r_scan <= '0;
            else if (w_ctl.scan) r_scan <= r_scan + CNT_W'(1);
            if (w_ctl.apply) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= w_req;
            r_ok   <= n_ok;
            r_st   <= n_st;
            r_tgt  <= n_tgt;
            r_word <= w_word;
        end
        if (w_ctl.apply) begin
            r_out_data <= {5'd0, (n_count == '0), w_count_ext[6:0], r_st, w_found, w_rdata};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_WIDTH-1:0] w_entry_up, w_entry_dn, w_rd_up;
        logic                  w_hit_up, w_above_up;

        if (g == CAPACITY - 1) begin : g_top
            assign w_entry_up = w_entry[g];
            assign w_hit_up   = 1'b0;
            assign w_above_up = 1'b0;
            assign w_rd_up    = '0;
        end else begin : g_mid
            assign w_entry_up = w_entry[g+1];
            assign w_hit_up   = w_hit[g+1];
            assign w_above_up = w_above[g+1];
            assign w_rd_up    = w_rd[g+1];
        end

        if (g == 0) begin : g_bot
            assign w_entry_dn = w_entry[g];
        end else begin : g_low
            assign w_entry_dn = w_entry[g-1];
        end

        olist_cell #(
            .IDX        (g),
            .CNT_W      (CNT_W),
            .WORD_WIDTH (WORD_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_word     (r_word),
            .i_tgt      (r_tgt),
            .i_count    (r_count),
            .i_entry_up (w_entry_up),
            .i_entry_dn (w_entry_dn),
            .i_hit_up   (w_hit_up),
            .i_above_up (w_above_up),
            .i_rd_up    (w_rd_up),
            .o_entry    (w_entry[g]),
            .o_hit      (w_hit[g]),
            .o_above    (w_above[g]),
            .o_rd       (w_rd[g])
        );
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("fill count above capacity");

    a_accept_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_CAPTURE))
        else $error("accepted word did not start capture");

    a_apply_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.apply |=> m_axis_tvalid)
        else $error("cell update without result word");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[42] == (m_axis_tdata[41:35] == 7'd0)))
        else $error("empty flag disagrees with count");

    a_scan_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !s_axis_tready)
        else $error("input ready during chain scan");

endmodule
